### rtl/gspc_pkg.sv
package gspc_pkg;

  // Pixel store geometry.
  localparam int NUM_PIXELS = 65536;
  localparam int PIX_AW     = $clog2(NUM_PIXELS);

  localparam int PED_W  = 22;
  localparam int GAIN_W = 24;
  localparam int CNT_W  = 24;
  localparam int DIFF_W = PED_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W;
  localparam int TERM_W = PROD_W - 20;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [31:0]      VALUE_MAX = 32'h7fff_ffff;
  localparam logic [13:0]      ADC_FULL  = 14'h3fff;

  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_WRITE   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_HIGH  = 2'd0,
    MODE_MID   = 2'd1,
    MODE_BAD   = 2'd2,
    MODE_LOW   = 2'd3
  } gain_mode_t;

  typedef enum logic [2:0] {
    SEL_PED0  = 3'd0,
    SEL_PED1  = 3'd1,
    SEL_PED3  = 3'd2,
    SEL_GAIN0 = 3'd3,
    SEL_GAIN1 = 3'd4,
    SEL_GAIN3 = 3'd5,
    SEL_GOOD  = 3'd6,
    SEL_NONE  = 3'd7
  } table_sel_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] pixel;
    logic [15:0] raw_word;
    logic        frame_end;
    logic [2:0]  table_sel;
    logic [23:0] cal_value;
  } in_req_t;

  typedef struct packed {
    logic [15:0]        out_pixel;
    logic signed [31:0] value;
    logic               invalid;
    logic [CNT_W-1:0]   count_mid_gain;
    logic [CNT_W-1:0]   count_low_gain;
    logic               last;
  } out_res_t;

  // One calibration entry per pixel.
  typedef struct packed {
    logic [PED_W-1:0]  ped0;
    logic [PED_W-1:0]  ped1;
    logic [PED_W-1:0]  ped3;
    logic [GAIN_W-1:0] gain0;
    logic [GAIN_W-1:0] gain1;
    logic [GAIN_W-1:0] gain3;
    logic              good;
  } cal_entry_t;

  // Running sum entry: invalid flag and the 32-bit sum.
  typedef struct packed {
    logic        inv;
    logic [31:0] sum;
  } sum_entry_t;

endpackage

### rtl/gain_switching_pixel_calibrator.sv
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid / in_stall | in_req  (in_req_t)
// out_     | output    | out_valid/out_stall | out_res (out_res_t)
// cfg_     | input     | cfg_we              | cfg_wdata (frames_to_sum)
//
// One request is taken every cycle while the output is not stalled; a convert
// request of the last frame passes through the stage 1 and stage 2 registers
// into the output register. The rate is set by the single port pair of the sum
// store, which is read in stage 1 and written back in stage 2.
// Reset is synchronous and active low; it clears the pipeline valid bits, the
// frame counter, the good-pixel counts and sets frames_to_sum to 1.
// A stall on the output freezes the whole pipeline, memories included.
module gain_switching_pixel_calibrator
  import gspc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Memories: calibration entries and running sums.
  cal_entry_t cal_mem [NUM_PIXELS];
  sum_entry_t sum_mem [NUM_PIXELS];

  logic advance;
  logic in_take;
  logic [PIX_AW-1:0] in_addr;

  logic [7:0] fts_r;
  logic [7:0] fc_r;
  logic [8:0] nsum;
  logic       in_lastf;

  // Stage 1 registers: the calibration read is in flight.
  logic              s1_valid_r;
  logic [15:0]       s1_pixel_r;
  logic [13:0]       s1_adc_r;
  gain_mode_t        s1_mode_r;
  logic              s1_first_r;
  logic              s1_lastf_r;
  logic              s1_fend_r;
  cal_entry_t        cal_rd_r;

  // Stage 2 registers: product ready, sum read in flight.
  logic                     s2_valid_r;
  logic [15:0]              s2_pixel_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic                     s2_bad_r;
  logic                     s2_first_r;
  logic                     s2_lastf_r;
  logic                     s2_fend_r;
  logic                     s2_inc_mid_r;
  logic                     s2_inc_low_r;
  sum_entry_t               sum_rd_r;
  logic                     fwd_r;
  sum_entry_t               fwd_data_r;

  logic [CNT_W-1:0] mid_cnt_r, low_cnt_r;
  logic [CNT_W-1:0] mid_cnt_nxt, low_cnt_nxt;

  logic             out_valid_r;
  out_res_t         out_res_r;

  // Stage 1 combinational terms.
  logic [PED_W-1:0]         s1_ped;
  logic [GAIN_W-1:0]        s1_gain;
  logic signed [DIFF_W-1:0] s1_diff;
  logic                     s1_bad;

  // Stage 2 combinational terms.
  logic signed [TERM_W-1:0] s2_term;
  sum_entry_t               s2_old;
  logic signed [32:0]       s2_sum_wide;
  logic [31:0]              s2_sum;
  logic                     s2_inv;
  sum_entry_t               sum_wr;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign in_take  = in_valid && advance;
  assign in_addr  = in_req.pixel[PIX_AW-1:0];

  assign nsum     = (fts_r == 8'd0) ? 9'd1 : {1'b0, fts_r};
  assign in_lastf = ({1'b0, fc_r} + 9'd1) >= nsum;

  // Configuration and frame counting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fts_r <= 8'd1;
      fc_r  <= 8'd0;
    end else begin
      if (cfg_we) begin
        fts_r <= cfg_wdata;
      end
      if (in_take && in_req.cmd == CMD_CONVERT && in_req.frame_end) begin
        fc_r <= in_lastf ? 8'd0 : fc_r + 8'd1;
      end
    end
  end

  // Calibration memory: field writes on write requests, read for converts.
  always_ff @(posedge clk) begin
    if (in_take && in_req.cmd == CMD_WRITE) begin
      unique case (table_sel_t'(in_req.table_sel))
        SEL_PED0:  cal_mem[in_addr].ped0  <= in_req.cal_value[PED_W-1:0];
        SEL_PED1:  cal_mem[in_addr].ped1  <= in_req.cal_value[PED_W-1:0];
        SEL_PED3:  cal_mem[in_addr].ped3  <= in_req.cal_value[PED_W-1:0];
        SEL_GAIN0: cal_mem[in_addr].gain0 <= in_req.cal_value;
        SEL_GAIN1: cal_mem[in_addr].gain1 <= in_req.cal_value;
        SEL_GAIN3: cal_mem[in_addr].gain3 <= in_req.cal_value;
        SEL_GOOD:  cal_mem[in_addr].good  <= in_req.cal_value[0];
        SEL_NONE:  ;
        default:   ;
      endcase
    end
    if (advance) begin
      cal_rd_r <= cal_mem[in_addr];
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_take && in_req.cmd == CMD_CONVERT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pixel_r <= in_req.pixel;
      s1_adc_r   <= in_req.raw_word[13:0];
      s1_mode_r  <= gain_mode_t'(in_req.raw_word[15:14]);
      s1_first_r <= fc_r == 8'd0;
      s1_lastf_r <= in_lastf;
      s1_fend_r  <= in_req.frame_end;
    end
  end

  always_comb begin
    s1_ped  = cal_rd_r.ped0;
    s1_gain = cal_rd_r.gain0;
    s1_bad  = 1'b0;
    unique case (s1_mode_r)
      MODE_HIGH: begin
        s1_ped  = cal_rd_r.ped0;
        s1_gain = cal_rd_r.gain0;
      end
      MODE_MID: begin
        s1_ped  = cal_rd_r.ped1;
        s1_gain = cal_rd_r.gain1;
      end
      MODE_LOW: begin
        s1_ped  = cal_rd_r.ped3;
        s1_gain = cal_rd_r.gain3;
        s1_bad  = (s1_adc_r == 14'd0) || (s1_adc_r == ADC_FULL);
      end
      MODE_BAD: begin
        // The term is forced to zero through a zero gain.
        s1_ped  = '0;
        s1_gain = '0;
        s1_bad  = 1'b1;
      end
      default: ;
    endcase
    s1_diff = $signed({1'b0, s1_adc_r, 8'd0}) - $signed({1'b0, s1_ped});
  end

  // Sum store read for the stage 1 pixel; forwarding covers a write of the
  // same pixel from stage 2 in the same cycle.
  always_ff @(posedge clk) begin
    if (advance) begin
      sum_rd_r   <= sum_mem[s1_pixel_r[PIX_AW-1:0]];
      fwd_data_r <= sum_wr;
    end
    if (advance && s2_valid_r) begin
      sum_mem[s2_pixel_r[PIX_AW-1:0]] <= sum_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
      fwd_r      <= s1_valid_r && s2_valid_r && (s1_pixel_r == s2_pixel_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pixel_r   <= s1_pixel_r;
      s2_prod_r    <= PROD_W'(s1_diff * $signed({1'b0, s1_gain}));
      s2_bad_r     <= s1_bad;
      s2_first_r   <= s1_first_r;
      s2_lastf_r   <= s1_lastf_r;
      s2_fend_r    <= s1_fend_r;
      s2_inc_mid_r <= (s1_mode_r == MODE_MID) && cal_rd_r.good;
      s2_inc_low_r <= (s1_mode_r == MODE_LOW) && cal_rd_r.good;
    end
  end

  // Stage 2: floor shift, accumulate and saturate.
  always_comb begin
    s2_term = s2_prod_r[PROD_W-1:20];
    s2_old  = fwd_r ? fwd_data_r : sum_rd_r;
    if (s2_first_r) begin
      s2_sum_wide = 33'(s2_term);
      s2_inv      = s2_bad_r;
    end else begin
      s2_sum_wide = $signed({s2_old.sum[31], s2_old.sum}) + 33'(s2_term);
      s2_inv      = s2_bad_r || s2_old.inv;
    end
    priority if (s2_sum_wide > 33'sh0_7fff_ffff) begin
      s2_sum = VALUE_MAX;
    end else if (s2_sum_wide < -33'sh0_8000_0000) begin
      s2_sum = 32'h8000_0000;
    end else begin
      s2_sum = s2_sum_wide[31:0];
    end
    sum_wr.inv = s2_inv;
    sum_wr.sum = s2_sum;
    mid_cnt_nxt = (s2_inc_mid_r && mid_cnt_r != CNT_MAX) ? mid_cnt_r + 1'b1 : mid_cnt_r;
    low_cnt_nxt = (s2_inc_low_r && low_cnt_r != CNT_MAX) ? low_cnt_r + 1'b1 : low_cnt_r;
  end

  // Good-pixel counts, cleared after the last request of an image.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_cnt_r <= '0;
      low_cnt_r <= '0;
    end else if (advance && s2_valid_r) begin
      if (s2_lastf_r && s2_fend_r) begin
        mid_cnt_r <= '0;
        low_cnt_r <= '0;
      end else begin
        mid_cnt_r <= mid_cnt_nxt;
        low_cnt_r <= low_cnt_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r && s2_lastf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r.out_pixel      <= s2_pixel_r;
      out_res_r.value          <= s2_inv ? VALUE_MAX : s2_sum;
      out_res_r.invalid        <= s2_inv;
      out_res_r.count_mid_gain <= mid_cnt_nxt;
      out_res_r.count_low_gain <= low_cnt_nxt;
      out_res_r.last           <= s2_fend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // An invalid result always carries the largest positive value.
  a_inv_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.invalid) |-> (out_res_r.value == VALUE_MAX))
    else $error("invalid result without full-scale value");

  // Forwarding is only ever flagged behind an active stage 2.
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_r) |-> $past(s2_valid_r))
    else $error("forward flag without a stage 2 write");

  // A stalled result stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed");

endmodule
